### sv/lae_pkg.sv
// lae_pkg: shared types, field widths, register codes and reset values
// for the linear adsr envelope unit; no dependencies
`timescale 1ns / 1ps

package lae_pkg;

   // field and register widths
   localparam int SAMPLE_TIME_BITS  = 32;
   localparam int CMD_BITS          = 2;
   localparam int LEVEL_BITS        = 16;
   localparam int STAGE_BITS        = 2;
   localparam int DUR_BITS          = 24;
   localparam int CSR_DATA_BITS     = 24;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int TIME_BITS_DEFAULT = 32;

   // multiplier operand width: levels and level differences fit 16 bits
   localparam int MUL_BITS = 16;

   // output clamp limits, Q1.15
   localparam int LEVEL_MAX   = 32768;
   localparam int LEVEL_FLOOR = 3;

   // register reset values
   localparam logic [DUR_BITS-1:0]   ATTACK_RESET  = 24'd4410;
   localparam logic [DUR_BITS-1:0]   DECAY_RESET   = 24'd441;
   localparam logic [DUR_BITS-1:0]   RELEASE_RESET = 24'd8820;
   localparam logic [LEVEL_BITS-1:0] PEAK_RESET    = 16'd32768;
   localparam logic [LEVEL_BITS-1:0] SUSTAIN_RESET = 16'd26214;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_SAMPLE   = 2'd0,
      CMD_NOTE_ON  = 2'd1,
      CMD_NOTE_OFF = 2'd2
   } cmd_type;

   typedef enum logic [STAGE_BITS-1:0] {
      STAGE_ATTACK  = 2'd0,
      STAGE_DECAY   = 2'd1,
      STAGE_SUSTAIN = 2'd2,
      STAGE_RELEASE = 2'd3
   } stage_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ATTACK  = 3'd0,
      REG_DECAY   = 3'd1,
      REG_RELEASE = 3'd2,
      REG_PEAK    = 3'd3,
      REG_SUSTAIN = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELECT,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

### sv/lae_if.sv
// lae_req_if / lae_rsp_if: valid-ready channels for command items and
// envelope result items; depends on lae_pkg
`timescale 1ns / 1ps

interface lae_req_if;
   logic                                valid;
   logic                                ready;
   logic [lae_pkg::CMD_BITS-1:0]         cmd;
   logic [lae_pkg::SAMPLE_TIME_BITS-1:0] sample_time;

   modport source (output valid, output cmd, output sample_time, input ready);
   modport sink   (input valid, input cmd, input sample_time, output ready);
endinterface

interface lae_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lae_pkg::LEVEL_BITS-1:0] amplitude;
   logic [lae_pkg::STAGE_BITS-1:0] stage;

   modport source (output valid, output amplitude, output stage, input ready);
   modport sink   (input valid, input amplitude, input stage, output ready);
endinterface

### sv/lae_mul.sv
// lae_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on lae_pkg
`timescale 1ns / 1ps

module lae_mul #(
   parameter int TIME_BITS = lae_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [TIME_BITS-1:0]                   mcand,
   input  logic [lae_pkg::MUL_BITS-1:0]           mplier,
   output logic                                   done,
   output logic [TIME_BITS+lae_pkg::MUL_BITS-1:0] product
);

   localparam int MB    = lae_pkg::MUL_BITS;
   localparam int PW    = TIME_BITS + MB;
   localparam int CNT_W = $clog2(MB);

   logic                 busy_ff, done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [TIME_BITS-1:0] mcand_ff;
   logic [TIME_BITS:0]   sum;

   // if the low bit is set, add the multiplicand into the high half; then shift right one bit
   always_comb begin
      sum = {1'b0, prod_ff[PW-1:MB]} + {1'b0, mcand_ff};
      if (prod_ff[0]) begin
         prod_in = {sum, prod_ff[MB-1:1]};
      end else begin
         prod_in = {1'b0, prod_ff[PW-1:1]};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MB - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff  <= {{TIME_BITS{1'b0}}, mplier};
         mcand_ff <= mcand;
      end else if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

### sv/lae_div.sv
// lae_div: restoring bit-serial divider, one quotient bit per cycle,
// truncating; depends on lae_pkg
`timescale 1ns / 1ps

module lae_div #(
   parameter int TIME_BITS = lae_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [TIME_BITS+lae_pkg::MUL_BITS-1:0] dividend,
   input  logic [lae_pkg::DUR_BITS-1:0]           divisor,
   output logic                                   done,
   output logic [TIME_BITS+lae_pkg::MUL_BITS-1:0] quotient
);

   localparam int PW    = TIME_BITS + lae_pkg::MUL_BITS;
   localparam int DB    = lae_pkg::DUR_BITS;
   localparam int CNT_W = $clog2(PW);

   logic              busy_ff, done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PW-1:0]     quo_ff, quo_in;
   logic [DB-1:0]     rem_ff, rem_in, dvs_ff;
   logic [DB:0]       shifted;
   logic [DB+1:0]     trial;
   logic              fits;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[PW-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      fits    = ~trial[DB+1];
      rem_in  = fits ? trial[DB-1:0] : shifted[DB-1:0];
      quo_in  = {quo_ff[PW-2:0], fits};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/linear_adsr_envelope_unit.sv
// Linear ADSR envelope unit. A note-on or note-off item is taken in the idle
// state and gives no result. A sample item in attack, decay or release runs a
// bit-serial multiply (lae_mul) and then a bit-serial divide (lae_div) before
// its result is loaded; a sample in sustain skips both. One item is worked on
// at a time; the next is accepted once the previous result sits in the output
// register. Write the csr registers only while the unit is idle.
// Depends on lae_pkg, lae_if, lae_mul and lae_div.
`timescale 1ns / 1ps

module linear_adsr_envelope_unit #(
   parameter int TIME_BITS = lae_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   lae_req_if.sink                             req_ch,
   lae_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [lae_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lae_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int DB  = lae_pkg::DUR_BITS;
   localparam int LB  = lae_pkg::LEVEL_BITS;
   localparam int MB  = lae_pkg::MUL_BITS;
   localparam int STB = lae_pkg::SAMPLE_TIME_BITS;
   localparam int PW  = TIME_BITS + MB;
   localparam int VW  = PW + 2;
   localparam int CW  = ((TIME_BITS > DB) ? TIME_BITS : DB) + 2;

   // configuration registers
   logic [DB-1:0] attack_ff, decay_ff, release_ff;
   logic [LB-1:0] peak_ff, sustain_ff;

   // note state
   logic                 note_held_ff;
   logic [TIME_BITS-1:0] on_time_ff, off_time_ff, diff_ff;
   logic [TIME_BITS-1:0] req_time;

   // sequencer and operand registers
   lae_pkg::state_type   state_ff, state_in;
   lae_pkg::stage_type   stage_ff, sel_stage;
   logic                 neg_ff, sel_neg;
   logic                 zero_q_ff;
   logic [LB-1:0]        base_ff, sel_base;
   logic [DB-1:0]        divisor_ff, sel_div;
   logic [TIME_BITS-1:0] sel_mcand;
   logic [MB-1:0]        sel_mplier;

   // output register
   logic                 rsp_valid_ff;
   logic [LB-1:0]        rsp_amp_ff;
   lae_pkg::stage_type   rsp_stage_ff;

   logic req_accept, rsp_load;
   logic mul_start, mul_done, div_start, div_done;
   logic [PW-1:0] product, quotient;

   // sample time zero-extended or truncated to the time width
   if (TIME_BITS > STB) begin : g_time_wide
      assign req_time = {{(TIME_BITS - STB){1'b0}}, req_ch.sample_time};
   end else if (TIME_BITS == STB) begin : g_time_same
      assign req_time = req_ch.sample_time;
   end else begin : g_time_narrow
      assign req_time = req_ch.sample_time[TIME_BITS-1:0];
   end

   assign req_accept = req_ch.valid && req_ch.ready;

   // csr writes, out-of-range indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= lae_pkg::ATTACK_RESET;
         decay_ff   <= lae_pkg::DECAY_RESET;
         release_ff <= lae_pkg::RELEASE_RESET;
         peak_ff    <= lae_pkg::PEAK_RESET;
         sustain_ff <= lae_pkg::SUSTAIN_RESET;
      end else if (csr_we) begin
         case (lae_pkg::reg_index_type'(csr_index))
            lae_pkg::REG_ATTACK:  attack_ff  <= csr_wdata[DB-1:0];
            lae_pkg::REG_DECAY:   decay_ff   <= csr_wdata[DB-1:0];
            lae_pkg::REG_RELEASE: release_ff <= csr_wdata[DB-1:0];
            lae_pkg::REG_PEAK:    peak_ff    <= csr_wdata[LB-1:0];
            lae_pkg::REG_SUSTAIN: sustain_ff <= csr_wdata[LB-1:0];
            default: ;
         endcase
      end
   end

   // note commands and time difference capture
   always_ff @(posedge clock) begin
      if (reset) begin
         note_held_ff <= 1'b0;
         on_time_ff   <= '0;
         off_time_ff  <= '0;
      end else if (req_accept) begin
         case (lae_pkg::cmd_type'(req_ch.cmd))
            lae_pkg::CMD_NOTE_ON: begin
               on_time_ff   <= req_time;
               note_held_ff <= 1'b1;
            end
            lae_pkg::CMD_NOTE_OFF: begin
               off_time_ff  <= req_time;
               note_held_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         diff_ff <= req_time - (note_held_ff ? on_time_ff : off_time_ff);
      end
   end

   // stage selection and multiply/divide operands
   logic signed [CW-1:0] life_ext, a_ext, ad_ext, decay_off;
   logic [DB-1:0]        a_dur, d_dur, r_dur;
   logic [TIME_BITS-1:0] life_mag;
   logic [LB-1:0]        lvl_mag;
   logic                 lvl_neg;

   always_comb begin
      a_dur     = (attack_ff == '0)  ? DB'(1) : attack_ff;
      d_dur     = (decay_ff == '0)   ? DB'(1) : decay_ff;
      r_dur     = (release_ff == '0) ? DB'(1) : release_ff;
      life_ext  = {{(CW - TIME_BITS){diff_ff[TIME_BITS-1]}}, diff_ff};
      a_ext     = {{(CW - DB){1'b0}}, a_dur};
      ad_ext    = a_ext + {{(CW - DB){1'b0}}, d_dur};
      decay_off = life_ext - a_ext;
      life_mag  = diff_ff[TIME_BITS-1] ? (~diff_ff + 1'b1) : diff_ff;
      lvl_neg   = sustain_ff < peak_ff;
      lvl_mag   = lvl_neg ? (peak_ff - sustain_ff) : (sustain_ff - peak_ff);

      sel_stage  = lae_pkg::STAGE_RELEASE;
      sel_mcand  = life_mag;
      sel_mplier = sustain_ff;
      sel_neg    = ~diff_ff[TIME_BITS-1];
      sel_base   = sustain_ff;
      sel_div    = r_dur;
      if (note_held_ff) begin
         if (life_ext <= a_ext) begin
            sel_stage  = lae_pkg::STAGE_ATTACK;
            sel_mplier = peak_ff;
            sel_neg    = diff_ff[TIME_BITS-1];
            sel_base   = '0;
            sel_div    = a_dur;
         end else if (life_ext <= ad_ext) begin
            sel_stage  = lae_pkg::STAGE_DECAY;
            sel_mcand  = decay_off[TIME_BITS-1:0];
            sel_mplier = lvl_mag;
            sel_neg    = lvl_neg;
            sel_base   = peak_ff;
            sel_div    = d_dur;
         end else begin
            sel_stage = lae_pkg::STAGE_SUSTAIN;
            sel_neg   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == lae_pkg::ST_SELECT) begin
         stage_ff   <= sel_stage;
         neg_ff     <= sel_neg;
         base_ff    <= sel_base;
         divisor_ff <= sel_div;
         zero_q_ff  <= (sel_stage == lae_pkg::STAGE_SUSTAIN);
      end
   end

   // serial arithmetic units
   lae_mul #(.TIME_BITS(TIME_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (sel_mcand),
      .mplier  (sel_mplier),
      .done    (mul_done),
      .product (product)
   );

   lae_div #(.TIME_BITS(TIME_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // final level: base plus or minus quotient, then floor and clamp
   logic [VW-1:0] lvl_sum, base_w, q_w;
   logic [LB-1:0] amp_val;

   always_comb begin
      base_w  = {{(VW - LB){1'b0}}, base_ff};
      q_w     = zero_q_ff ? '0 : {2'b00, quotient};
      lvl_sum = neg_ff ? (base_w - q_w) : (base_w + q_w);
      if (lvl_sum[VW-1] || (lvl_sum <= VW'(lae_pkg::LEVEL_FLOOR))) begin
         amp_val = '0;
      end else if (lvl_sum > VW'(lae_pkg::LEVEL_MAX)) begin
         amp_val = LB'(lae_pkg::LEVEL_MAX);
      end else begin
         amp_val = lvl_sum[LB-1:0];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lae_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         lae_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid && (req_ch.cmd == lae_pkg::CMD_SAMPLE)) begin
               state_in = lae_pkg::ST_SELECT;
            end
         end
         lae_pkg::ST_SELECT: begin
            if (sel_stage == lae_pkg::STAGE_SUSTAIN) begin
               state_in = lae_pkg::ST_FINISH;
            end else begin
               mul_start = 1'b1;
               state_in  = lae_pkg::ST_MUL;
            end
         end
         lae_pkg::ST_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = lae_pkg::ST_DIV;
            end
         end
         lae_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = lae_pkg::ST_FINISH;
            end
         end
         lae_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = lae_pkg::ST_IDLE;
            end
         end
         default: state_in = lae_pkg::ST_IDLE;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_amp_ff   <= amp_val;
         rsp_stage_ff <= stage_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.amplitude = rsp_amp_ff;
   assign rsp_ch.stage     = rsp_stage_ff;

`ifndef ASSERT_OFF
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_ch.cmd == lae_pkg::CMD_SAMPLE))
         |=> (state_ff == lae_pkg::ST_SELECT))
      else $error("sample item did not start the sequencer");

   a_note_on_holds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_ch.cmd == lae_pkg::CMD_NOTE_ON)) |=> note_held_ff)
      else $error("note on did not set the held flag");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == lae_pkg::ST_MUL))
      else $error("multiplier finished outside the multiply state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == lae_pkg::ST_DIV))
      else $error("divider finished outside the divide state");

   a_amp_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (amp_val != '0))
         |-> ((amp_val > LB'(lae_pkg::LEVEL_FLOOR))
              && (amp_val <= LB'(lae_pkg::LEVEL_MAX))))
      else $error("amplitude outside the clamped range");
`endif

endmodule

### tb/sv/lae_envelope_checker.sv
// lae_envelope_checker: watches the command, result and csr ports of the linear
// adsr envelope unit, predicts each envelope point and compares it with the result
// depends on lae_pkg
`timescale 1ns / 1ps

module lae_envelope_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [lae_pkg::CMD_BITS-1:0]         req_cmd,
   input  logic [lae_pkg::SAMPLE_TIME_BITS-1:0] req_sample_time,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [lae_pkg::LEVEL_BITS-1:0]       rsp_amplitude,
   input  logic [lae_pkg::STAGE_BITS-1:0]       rsp_stage,
   input  logic                                 csr_we,
   input  logic [lae_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lae_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output int                                   failures,
   output int                                   pending_results
);

   localparam int TW = lae_pkg::SAMPLE_TIME_BITS;
   localparam int LW = lae_pkg::LEVEL_BITS;
   localparam int DW = lae_pkg::DUR_BITS;

   typedef struct packed {
      logic [LW-1:0]      amplitude;
      lae_pkg::stage_type stage;
   } envelope_point_type;

   // envelope points still owed by the unit, oldest first
   envelope_point_type expected_points[$];

   // shadow of the csr registers
   logic [DW-1:0] attack_len;
   logic [DW-1:0] decay_len;
   logic [DW-1:0] release_len;
   logic [LW-1:0] peak;
   logic [LW-1:0] sustain;

   // note state
   logic          note_held;
   logic [TW-1:0] on_time;
   logic [TW-1:0] off_time;

   int errors = 0;

   assign failures = errors;

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: envelope check failed, %s: got %0d, expected %0d",
               $realtime, what, got, want);
      errors++;
   endtask

   // wrapped time difference, read as signed
   function automatic longint elapsed(logic [TW-1:0] now, logic [TW-1:0] mark);
      logic signed [TW-1:0] delta;
      delta = now - mark;
      return longint'(delta);
   endfunction

   // envelope level and stage at a sample time; division truncates toward zero
   function automatic envelope_point_type envelope_at(logic [TW-1:0] stamp);
      envelope_point_type point;
      longint a, d, r, pk, sus, life, level;
      a   = (attack_len == '0)  ? 64'sd1 : longint'(attack_len);
      d   = (decay_len == '0)   ? 64'sd1 : longint'(decay_len);
      r   = (release_len == '0) ? 64'sd1 : longint'(release_len);
      pk  = longint'(peak);
      sus = longint'(sustain);
      if (note_held) begin
         life = elapsed(stamp, on_time);
         if (life <= a) begin
            level = (life * pk) / a;
            point.stage = lae_pkg::STAGE_ATTACK;
         end else if (life <= a + d) begin
            level = ((life - a) * (sus - pk)) / d + pk;
            point.stage = lae_pkg::STAGE_DECAY;
         end else begin
            level = sus;
            point.stage = lae_pkg::STAGE_SUSTAIN;
         end
      end else begin
         // release always ramps from the sustain level
         level = (elapsed(stamp, off_time) * (-sus)) / r + sus;
         point.stage = lae_pkg::STAGE_RELEASE;
      end
      if (level <= lae_pkg::LEVEL_FLOOR) level = 0;
      if (level > lae_pkg::LEVEL_MAX) level = lae_pkg::LEVEL_MAX;
      point.amplitude = level[LW-1:0];
      return point;
   endfunction

   // track csr writes, predict on accepted items, compare accepted results
   always @(posedge clock) begin
      envelope_point_type want;
      if (reset) begin
         attack_len  = lae_pkg::ATTACK_RESET;
         decay_len   = lae_pkg::DECAY_RESET;
         release_len = lae_pkg::RELEASE_RESET;
         peak        = lae_pkg::PEAK_RESET;
         sustain     = lae_pkg::SUSTAIN_RESET;
         note_held   = 1'b0;
         on_time     = '0;
         off_time    = '0;
         expected_points.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               lae_pkg::REG_ATTACK:  attack_len  = csr_wdata[DW-1:0];
               lae_pkg::REG_DECAY:   decay_len   = csr_wdata[DW-1:0];
               lae_pkg::REG_RELEASE: release_len = csr_wdata[DW-1:0];
               lae_pkg::REG_PEAK:    peak        = csr_wdata[LW-1:0];
               lae_pkg::REG_SUSTAIN: sustain     = csr_wdata[LW-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_cmd)
               lae_pkg::CMD_NOTE_ON: begin
                  on_time   = req_sample_time;
                  note_held = 1'b1;
               end
               lae_pkg::CMD_NOTE_OFF: begin
                  off_time  = req_sample_time;
                  note_held = 1'b0;
               end
               lae_pkg::CMD_SAMPLE:
                  expected_points.push_back(envelope_at(req_sample_time));
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("result with no sample item waiting", rsp_amplitude, -1);
            end else begin
               want = expected_points.pop_front();
               if (rsp_amplitude !== want.amplitude)
                  report_mismatch("amplitude", rsp_amplitude, want.amplitude);
               if (rsp_stage !== want.stage)
                  report_mismatch("stage", rsp_stage, want.stage);
            end
         end
      end
      pending_results <= expected_points.size();
   end

endmodule

### tb/sv/tb.sv
// tb: stimulus and verdict for the linear adsr envelope unit; the envelope
// checker beside the unit does the prediction and comparison
// depends on lae_pkg, lae_if, linear_adsr_envelope_unit and lae_envelope_checker
`timescale 1ns / 1ps

module tb;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 100;
   localparam int STALL_LIMIT     = 5000;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int PHASES          = 6;

   localparam int CMD_W = lae_pkg::CMD_BITS;
   localparam int TW    = lae_pkg::SAMPLE_TIME_BITS;
   localparam int DUR_W = lae_pkg::DUR_BITS;
   localparam int LVL_W = lae_pkg::LEVEL_BITS;

   // command code the unit ignores
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_we;
   logic [lae_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [lae_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   lae_req_if req_ch ();
   lae_rsp_if rsp_ch ();

   int failures;
   int pending_results;
   int send_idle_pct = 6;
   int recv_idle_pct = 85;
   bit hold_request  = 1'b0;
   int stall_cycles  = 0;
   int notes_sent    = 0;

   // effective durations of the current setting, used to aim sample times
   int unsigned attack_eff;
   int unsigned decay_eff;
   int unsigned release_eff;

   linear_adsr_envelope_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lae_envelope_checker envelope_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_cmd         (req_ch.cmd),
      .req_sample_time (req_ch.sample_time),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_amplitude   (rsp_ch.amplitude),
      .rsp_stage       (rsp_ch.stage),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .failures        (failures),
      .pending_results (pending_results)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog: cycles with no item accepted on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("linear_adsr_envelope_unit: mismatch");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // offer one item and wait until the unit takes it; valid stays high after
   task automatic send_item(logic [CMD_W-1:0] code, logic [TW-1:0] stamp);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= code;
      req_ch.sample_time <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (code != CMD_UNUSED) notes_sent++;
   endtask

   // drop valid, wait for every result, then let the unit go quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(lae_pkg::reg_index_type idx,
                          logic [lae_pkg::CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic program_envelope(logic [DUR_W-1:0] a, logic [DUR_W-1:0] d,
                                   logic [DUR_W-1:0] r, logic [LVL_W-1:0] pk,
                                   logic [LVL_W-1:0] sus);
      put_reg(lae_pkg::REG_ATTACK, a);
      put_reg(lae_pkg::REG_DECAY, d);
      put_reg(lae_pkg::REG_RELEASE, r);
      put_reg(lae_pkg::REG_PEAK, {8'd0, pk});
      put_reg(lae_pkg::REG_SUSTAIN, {8'd0, sus});
      csr_we <= 1'b0;
      attack_eff  = (a == '0) ? 32'd1 : 32'(a);
      decay_eff   = (d == '0) ? 32'd1 : 32'(d);
      release_eff = (r == '0) ? 32'd1 : 32'(r);
   endtask

   // time offset aimed at the knees of a ramp, around them, before the event or anywhere
   function automatic logic [TW-1:0] pick_offset(int unsigned knee, int unsigned span);
      case ($urandom_range(0, 11))
         0: return 32'd0;
         1: return knee;
         2: return knee + 1;
         3: return span;
         4: return span + 1;
         5: return 32'd0 - $urandom_range(1, 64);
         6: return $urandom;
         default: return $urandom_range(0, span + span / 4 + 2);
      endcase
   endfunction

   // one note: on, samples while held, off, samples in release
   task automatic play_note();
      logic [TW-1:0] t_on;
      logic [TW-1:0] t_off;
      t_on = $urandom;
      send_item(lae_pkg::CMD_NOTE_ON, t_on);
      repeat ($urandom_range(1, 6))
         send_item(lae_pkg::CMD_SAMPLE,
                   t_on + pick_offset(attack_eff, attack_eff + decay_eff));
      t_off = t_on + pick_offset(attack_eff, attack_eff + decay_eff);
      send_item(lae_pkg::CMD_NOTE_OFF, t_off);
      repeat ($urandom_range(1, 6))
         send_item(lae_pkg::CMD_SAMPLE, t_off + pick_offset(release_eff, release_eff));
   endtask

   // stray items: any code at any time, breaking up note sequences
   task automatic send_noise();
      repeat ($urandom_range(1, 3))
         send_item(CMD_W'($urandom_range(0, 3)), $urandom);
   endtask

   // stimulus
   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= lae_pkg::REG_ATTACK;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= lae_pkg::CMD_SAMPLE;
      req_ch.sample_time <= '0;
      attack_eff  = 32'(lae_pkg::ATTACK_RESET);
      decay_eff   = 32'(lae_pkg::DECAY_RESET);
      release_eff = 32'(lae_pkg::RELEASE_RESET);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // never played: release ramp from time zero, with reset settings
      send_item(lae_pkg::CMD_SAMPLE, 32'd0);
      send_item(lae_pkg::CMD_SAMPLE, 32'd4410);
      send_item(lae_pkg::CMD_SAMPLE, 32'd8819);       // just above zero, floored
      send_item(lae_pkg::CMD_SAMPLE, 32'd8820);
      send_item(lae_pkg::CMD_SAMPLE, 32'hFFFF_FFFF);  // before note off: above sustain
      send_item(lae_pkg::CMD_SAMPLE, 32'h8000_0000);  // far before note off: saturates
      send_item(CMD_UNUSED, 32'h5555_5555);
      // note held across the time wrap
      send_item(lae_pkg::CMD_NOTE_ON, 32'hFFFF_FF00);
      send_item(lae_pkg::CMD_SAMPLE, 32'hFFFF_FEFF);  // before note on
      send_item(lae_pkg::CMD_SAMPLE, 32'hFFFF_FF00);
      send_item(lae_pkg::CMD_SAMPLE, 32'hFFFF_FF00 + 32'd2205);
      send_item(lae_pkg::CMD_SAMPLE, 32'hFFFF_FF00 + 32'd4410);
      send_item(lae_pkg::CMD_SAMPLE, 32'hFFFF_FF00 + 32'd4411);
      send_item(lae_pkg::CMD_SAMPLE, 32'hFFFF_FF00 + 32'd4851);
      send_item(lae_pkg::CMD_SAMPLE, 32'hFFFF_FF00 + 32'd4852);
      send_item(lae_pkg::CMD_SAMPLE, 32'h7FFF_FEFF);
      send_item(CMD_UNUSED, 32'hAAAA_AAAA);
      send_item(lae_pkg::CMD_NOTE_OFF, 32'h0001_0000);
      send_item(lae_pkg::CMD_SAMPLE, 32'h0001_0064);
      send_item(lae_pkg::CMD_SAMPLE, 32'h0000_FFFB);
      send_item(lae_pkg::CMD_SAMPLE, 32'h0001_0000 + 32'd8820);
      send_item(lae_pkg::CMD_NOTE_ON, 32'd0);
      send_item(lae_pkg::CMD_SAMPLE, 32'd1);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: program_envelope(24'd40, 24'd25, 24'd60, 16'd32768, 16'd20000);
            1: program_envelope(24'd1, 24'd1, 24'd1, 16'd32768, 16'd32768);
            2: program_envelope(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'd32768, 16'd0);
            3: program_envelope(24'd0, 24'd0, 24'd0, 16'd0, 16'd32768);
            4: program_envelope(DUR_W'($urandom_range(1, 3000)),
                                DUR_W'($urandom_range(1, 3000)),
                                DUR_W'($urandom_range(1, 3000)),
                                LVL_W'($urandom_range(0, 32768)),
                                LVL_W'($urandom_range(0, 32768)));
            default: program_envelope(DUR_W'($urandom_range(1, 24'hFF_FFFF)),
                                      DUR_W'($urandom_range(1, 24'hFF_FFFF)),
                                      DUR_W'($urandom_range(1, 24'hFF_FFFF)),
                                      LVL_W'($urandom_range(0, 32768)),
                                      LVL_W'($urandom_range(0, 32768)));
         endcase
         // idling: sender light and receiver heavy, then swapped, then none
         if (phase < 2) begin
            send_idle_pct = 6;
            recv_idle_pct = 85;
         end else if (phase < 4) begin
            send_idle_pct = 85;
            recv_idle_pct = 6;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase == 0 || phase == 4) hold_request = 1'b1;
         notes_sent = 0;
         while (notes_sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else play_note();
         end
      end

      settle();
      if (failures == 0)
         $display("linear_adsr_envelope_unit: match");
      else
         $display("linear_adsr_envelope_unit: mismatch");
      $finish;
   end

endmodule
